@@ rtl/esm_pkg.sv @@
package esm_pkg;

	localparam int unsigned CFG_IDX_W = 3;

	typedef enum logic [2:0] {
		CFG_IDLE_WINDOW = 3'd0,
		CFG_IDLE_HOLD   = 3'd1,
		CFG_HEARTBEAT   = 3'd2,
		CFG_MOTOR_SCALE = 3'd3,
		CFG_DRUM_SCALE  = 3'd4,
		CFG_ACCEL_SCALE = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		KIND_EDGE_A = 2'd0,
		KIND_EDGE_B = 2'd1,
		KIND_TICK   = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_MUL_MOTOR,
		ST_MUL_DRUM,
		ST_MUL_ACCEL,
		ST_DECIDE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic       edge_store;
		logic       tick_load;
		logic       div_start;
		logic       slot_next;
		logic [1:0] mul_sel;
		logic       mul_go;
		logic       decide;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic last_slot;
	} status_t;

endpackage

@@ rtl/esm_divider.sv @@
module esm_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] dividend,
	input  logic signed [31:0] divisor,
	input  logic [4:0]         frac_bits,
	output logic               done,
	output logic signed [31:0] quotient
);
	// Restoring division, one quotient bit per cycle, on magnitudes.
	logic [62:0] num_q;
	logic [31:0] den_q;
	logic [32:0] rem_q;
	logic [62:0] quo_q;
	logic [5:0]  cnt_q;
	logic        neg_q;
	logic        busy_q;
	logic        zero_q;
	logic [32:0] trial;
	logic [32:0] rem_sh;
	logic [31:0] abs_n;
	logic [31:0] abs_d;
	logic [63:0] qsat;

	assign abs_n = dividend[31] ? 32'(-dividend) : 32'(dividend);
	assign abs_d = divisor[31] ? 32'(-divisor) : 32'(divisor);
	assign rem_sh = {rem_q[31:0], num_q[62]};
	assign trial = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd63;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= 63'({31'd0, abs_n} << frac_bits);
			den_q <= abs_d;
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= dividend[31] ^ divisor[31];
			zero_q <= (divisor == 32'sd0);
		end else if (busy_q) begin
			num_q <= {num_q[61:0], 1'b0};
			if (!trial[32]) begin
				rem_q <= trial;
				quo_q <= {quo_q[61:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[61:0], 1'b0};
			end
		end
	end

	always_comb begin
		qsat = neg_q ? 64'(-{1'b0, quo_q}) : {1'b0, quo_q};
		if (zero_q) quotient = 32'sd0;
		else if (!neg_q && quo_q > 63'h7FFFFFFF) quotient = 32'h7FFFFFFF;
		else if (neg_q && quo_q > 63'h80000000) quotient = 32'h80000000;
		else quotient = qsat[31:0];
	end
endmodule

@@ rtl/esm_datapath.sv @@
module esm_datapath #(
	parameter int unsigned FRACTION_BITS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  esm_pkg::cmd_t      cmd,
	output esm_pkg::status_t   status,
	input  logic [1:0]         kind,
	input  logic [31:0]        capture_time,
	input  logic signed [31:0] encoder_count,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [31:0]        cfg_data,
	output logic signed [31:0] drum_speed,
	output logic signed [31:0] motor_accel,
	output logic signed [31:0] position_count,
	output logic               heartbeat_report,
	output logic               send
);
	logic [30:0] win_q;
	logic [15:0] hold_q, hbt_q;
	logic signed [31:0] kmot_q, kdrum_q, kacc_q;
	logic [31:0] st_q [4];
	logic [31:0] sc_q [4];
	logic [31:0] pt_q [4];
	logic [31:0] pc_q [4];
	logic signed [31:0] ps_q [4];
	logic pa_q, pb_q, hbm_q;
	logic [15:0] idc_q, bc_q;
	logic [1:0] slot_q;
	logic signed [34:0] ssum_q, csum_q;
	logic signed [31:0] motor_q, drum_q, acc_q, pos_q;
	logic send_q, flag_q;
	logic signed [31:0] dt, dc, quo;
	logic div_done;
	logic signed [31:0] ma, mb;
	logic signed [63:0] prod;
	logic signed [31:0] mres;
	logic signed [63:0] shf;
	logic signed [31:0] ssat, csat;
	logic [1:0] es;
	logic moving;
	logic [15:0] bc_dec, idc_dec;

	assign dt = 32'(st_q[slot_q] - pt_q[slot_q]);
	assign dc = 32'(sc_q[slot_q] - pc_q[slot_q]);

	esm_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(dc), .divisor(dt), .frac_bits(5'(FRACTION_BITS)),
		.done(div_done), .quotient(quo)
	);

	assign status.div_done = div_done;
	assign status.last_slot = (slot_q == 2'd3);

	function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
		if (v > 35'sh7FFFFFFF) return 32'h7FFFFFFF;
		else if (v < -35'sh80000000) return 32'h80000000;
		else return v[31:0];
	endfunction

	assign ssat = sat35(ssum_q);
	assign csat = sat35(csum_q);

	always_comb begin
		case (cmd.mul_sel)
			2'd0: begin ma = ssat; mb = kmot_q; end
			2'd1: begin ma = motor_q; mb = kdrum_q; end
			default: begin ma = csat; mb = kacc_q; end
		endcase
	end
	assign prod = ma * mb;
	assign shf = prod >>> FRACTION_BITS;
	always_comb begin
		if (shf > 64'sh7FFFFFFF) mres = 32'h7FFFFFFF;
		else if (shf < -64'sh80000000) mres = 32'h80000000;
		else mres = shf[31:0];
	end

	assign es = (kind == esm_pkg::KIND_EDGE_A) ? {1'b0, ~pa_q} : {1'b1, ~pb_q};
	assign moving = (ssum_q > $signed({4'd0, win_q})) || (ssum_q < -$signed({4'd0, win_q}));
	assign bc_dec = (bc_q != 16'd0) ? bc_q - 16'd1 : bc_q;
	assign idc_dec = idc_q - 16'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= 31'd64; hold_q <= 16'd64; hbt_q <= 16'd64;
			kmot_q <= 32'sd16777216; kdrum_q <= 32'sd16777216; kacc_q <= 32'sd16777216;
			for (int i = 0; i < 4; i++) begin
				st_q[i] <= '0; sc_q[i] <= '0; pt_q[i] <= '0; pc_q[i] <= '0; ps_q[i] <= '0;
			end
			pa_q <= 1'b0; pb_q <= 1'b0; hbm_q <= 1'b1;
			idc_q <= '0; bc_q <= 16'd1; slot_q <= '0;
			send_q <= 1'b0; flag_q <= 1'b0;
			ssum_q <= '0; csum_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					esm_pkg::CFG_IDLE_WINDOW: win_q <= cfg_data[30:0];
					esm_pkg::CFG_IDLE_HOLD: hold_q <= cfg_data[15:0];
					esm_pkg::CFG_HEARTBEAT: hbt_q <= cfg_data[15:0];
					esm_pkg::CFG_MOTOR_SCALE: kmot_q <= cfg_data;
					esm_pkg::CFG_DRUM_SCALE: kdrum_q <= cfg_data;
					esm_pkg::CFG_ACCEL_SCALE: kacc_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.edge_store) begin
				if (kind == esm_pkg::KIND_EDGE_A) pa_q <= ~pa_q;
				else pb_q <= ~pb_q;
				st_q[es] <= capture_time;
				sc_q[es] <= encoder_count;
			end
			if (cmd.tick_load) begin
				slot_q <= '0; ssum_q <= '0; csum_q <= '0;
			end
			if (cmd.slot_next) begin
				ssum_q <= ssum_q + 35'(quo);
				csum_q <= csum_q + 35'(quo) - 35'(ps_q[slot_q]);
				ps_q[slot_q] <= quo;
				pt_q[slot_q] <= st_q[slot_q];
				pc_q[slot_q] <= sc_q[slot_q];
				slot_q <= slot_q + 2'd1;
			end
			if (cmd.decide) begin
				send_q <= 1'b0; flag_q <= 1'b0;
				bc_q <= bc_dec;
				if (moving) begin
					send_q <= 1'b1; hbm_q <= 1'b0; idc_q <= hold_q;
				end else if (!hbm_q) begin
					idc_q <= idc_dec;
					if (idc_dec != 16'd0) send_q <= 1'b1;
					else begin hbm_q <= 1'b1; bc_q <= hbt_q; end
				end else if (bc_dec == 16'd0) begin
					send_q <= 1'b1; flag_q <= 1'b1; bc_q <= hbt_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick_load) pos_q <= encoder_count;
		if (cmd.mul_go) begin
			case (cmd.mul_sel)
				2'd0: motor_q <= mres;
				2'd1: drum_q <= mres;
				default: acc_q <= mres;
			endcase
		end
		if (cmd.out_load) begin
			drum_speed <= drum_q; motor_accel <= acc_q;
			position_count <= pos_q; heartbeat_report <= flag_q;
		end
	end
	assign send = send_q;
endmodule

@@ rtl/esm_ctrl.sv @@
module esm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       kind,
	output logic             out_valid,
	input  logic             out_ready,
	input  logic             send,
	input  esm_pkg::status_t status,
	output esm_pkg::cmd_t    cmd
);
	esm_pkg::state_t state_q, state_d;
	logic ov_q, ov_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= esm_pkg::ST_IDLE;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ov_q <= ov_d;
		end
	end

	assign out_valid = ov_q;

	always_comb begin
		state_d = state_q;
		ov_d = ov_q && !out_ready;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			esm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (kind == esm_pkg::KIND_EDGE_A || kind == esm_pkg::KIND_EDGE_B)
						cmd.edge_store = 1'b1;
					else if (kind == esm_pkg::KIND_TICK) begin
						cmd.tick_load = 1'b1;
						state_d = esm_pkg::ST_DIV_START;
					end
				end
			end
			esm_pkg::ST_DIV_START: begin
				cmd.div_start = 1'b1;
				state_d = esm_pkg::ST_DIV_WAIT;
			end
			esm_pkg::ST_DIV_WAIT: begin
				if (status.div_done) begin
					cmd.slot_next = 1'b1;
					state_d = status.last_slot ? esm_pkg::ST_MUL_MOTOR : esm_pkg::ST_DIV_START;
				end
			end
			esm_pkg::ST_MUL_MOTOR: begin
				cmd.mul_go = 1'b1; cmd.mul_sel = 2'd0;
				state_d = esm_pkg::ST_MUL_DRUM;
			end
			esm_pkg::ST_MUL_DRUM: begin
				cmd.mul_go = 1'b1; cmd.mul_sel = 2'd1;
				state_d = esm_pkg::ST_MUL_ACCEL;
			end
			esm_pkg::ST_MUL_ACCEL: begin
				cmd.mul_go = 1'b1; cmd.mul_sel = 2'd2;
				cmd.decide = 1'b1;
				state_d = esm_pkg::ST_DECIDE;
			end
			esm_pkg::ST_DECIDE: begin
				if (!send) state_d = esm_pkg::ST_IDLE;
				else if (!ov_q || out_ready) begin
					cmd.out_load = 1'b1;
					ov_d = 1'b1;
					state_d = esm_pkg::ST_IDLE;
				end
			end
			default: state_d = esm_pkg::ST_IDLE;
		endcase
	end
endmodule

@@ rtl/encoder_speed_meter_idle_heartbeat.sv @@
// Edges are taken one per cycle, back to back, while no tick is in progress.
// A tick holds the input until it is done: four divisions on the shared
// divider (start, 63 steps, finish), three multiplies and a decision step.
// A finished result waits in the output register while edges keep flowing; a tick
// that finds it still full waits in its decision step.
// Asynchronous active-low reset restores all slots, countdowns and configuration
// registers; the result, product and divider data registers are not reset.
module encoder_speed_meter_idle_heartbeat #(
	parameter int unsigned FRACTION_BITS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         kind,
	input  logic [31:0]        capture_time,
	input  logic signed [31:0] encoder_count,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] drum_speed,
	output logic signed [31:0] motor_accel,
	output logic signed [31:0] position_count,
	output logic               heartbeat_report,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [31:0]        cfg_data
);
	esm_pkg::cmd_t cmd;
	esm_pkg::status_t status;
	logic send;

	esm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .out_valid(out_valid), .out_ready(out_ready),
		.send(send), .status(status), .cmd(cmd)
	);

	esm_datapath #(.FRACTION_BITS(FRACTION_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.kind(kind), .capture_time(capture_time), .encoder_count(encoder_count),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.drum_speed(drum_speed), .motor_accel(motor_accel),
		.position_count(position_count), .heartbeat_report(heartbeat_report),
		.send(send)
	);

`ifndef ASSERT_OFF
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !in_ready) else $error("input taken during tick");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid) else $error("result not shown");
`endif
endmodule
